@@ design/ght_pkg.sv @@
// Shared types, widths and codes for the generation handle table.
// Used by ght_exec and generation_handle_table; depends on nothing else.
package ght_pkg;

   localparam int SLOTS    = 256;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int LINK_W   = IDX_W + 1;
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 16;
   localparam int GEN_W    = 8;
   localparam int OBJ_W    = 32;
   localparam int KIND_W   = 4;
   localparam int RIGHTS_W = 32;
   localparam int STATUS_W = 3;

   // Link value that marks the end of the free list or a root entry.
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_DERIVE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_STALE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_KIND      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RIGHTS    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NO_DERIVE = 3'd5;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [INDEX_W-1:0]  slot_index;
      logic [GEN_W-1:0]    slot_generation;
      logic [OBJ_W-1:0]    object_ref;
      logic [KIND_W-1:0]   object_kind;
      logic [RIGHTS_W-1:0] rights_value;
      logic [RIGHTS_W-1:0] rights_bound;
      logic [RIGHTS_W-1:0] required_rights;
      logic                kind_check;
   } item_type;

   // One row of the entry memory; the generation lives in its own memory.
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [RIGHTS_W-1:0] rights;
      logic [OBJ_W-1:0]    object;
      logic [LINK_W-1:0]   parent;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [GEN_W-1:0]    generation;
      logic [OBJ_W-1:0]    object;
      logic [KIND_W-1:0]   kind;
      logic [RIGHTS_W-1:0] rights;
      logic [LINK_W-1:0]   parent;
      logic [LINK_W-1:0]   live_count;
   } result_type;

   // State changes decided for one transaction.
   typedef struct packed {
      logic              take;
      logic              drop;
      logic              gen_wr;
      logic [LINK_W-1:0] head_in;
      logic [LINK_W-1:0] mark_in;
      logic [LINK_W-1:0] count_in;
      logic              data_wr;
      logic [IDX_W-1:0]  data_addr;
      row_type           data_row;
      logic [IDX_W-1:0]  rel_addr;
      logic [GEN_W-1:0]  gen_val;
      logic [LINK_W-1:0] link_val;
   } update_type;

endpackage

@@ design/ght_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
// No dependencies; used for every memory of the handle table.
module ght_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ght_exec.sv @@
// Decision logic for one transaction: checks, result fields and state updates.
// Depends on ght_pkg; instantiated by generation_handle_table.
module ght_exec (
   input  ght_pkg::item_type                 item,
   input  ght_pkg::row_type                  src_row,
   input  logic [ght_pkg::GEN_W-1:0]         src_gen,
   input  logic [ght_pkg::LINK_W-1:0]        head,
   input  logic [ght_pkg::GEN_W-1:0]         head_gen,
   input  logic [ght_pkg::LINK_W-1:0]        head_link,
   input  logic [ght_pkg::LINK_W-1:0]        mark,
   input  logic [ght_pkg::LINK_W-1:0]        count,
   input  logic [ght_pkg::RIGHTS_W-1:0]      derive_mask,
   output ght_pkg::result_type               rsp,
   output ght_pkg::update_type               upd
);

   logic [ght_pkg::IDX_W-1:0] slot;
   logic                      in_range;
   logic                      handle_ok;
   logic                      full;
   ght_pkg::row_type          new_row;

   assign slot      = item.slot_index[ght_pkg::IDX_W-1:0];
   assign in_range  = 32'(item.slot_index) < ght_pkg::SLOTS;
   assign handle_ok = in_range && (src_row.kind != '0) &&
                      (src_gen == item.slot_generation);
   assign full      = (head == ght_pkg::LINK_NONE);

   always_comb begin
      rsp           = '0;
      rsp.status    = ght_pkg::ST_OK;
      rsp.parent    = ght_pkg::LINK_NONE;
      upd           = '0;
      upd.head_in   = head;
      upd.mark_in   = mark;
      upd.count_in  = count;
      upd.data_addr = head[ght_pkg::IDX_W-1:0];
      upd.rel_addr  = slot;
      upd.gen_val   = src_gen + 1'b1;
      upd.link_val  = head;
      new_row       = '0;
      new_row.parent = ght_pkg::LINK_NONE;

      unique case (item.action)
         ght_pkg::ACT_INSERT: begin
            if (item.object_kind == '0) begin
               rsp.status = ght_pkg::ST_STALE;
            end else if (full) begin
               rsp.status = ght_pkg::ST_FULL;
            end else begin
               upd.take       = 1'b1;
               new_row.kind   = item.object_kind;
               new_row.rights = item.rights_value & item.rights_bound;
               new_row.object = item.object_ref;
               new_row.parent = ght_pkg::LINK_NONE;
            end
         end
         ght_pkg::ACT_REMOVE: begin
            if (!handle_ok) begin
               rsp.status = ght_pkg::ST_STALE;
            end else begin
               upd.drop = 1'b1;
            end
         end
         ght_pkg::ACT_LOOKUP: begin
            priority if (!handle_ok) begin
               rsp.status = ght_pkg::ST_STALE;
            end else if (item.kind_check && (src_row.kind != item.object_kind)) begin
               rsp.status = ght_pkg::ST_KIND;
            end else if ((src_row.rights & item.required_rights) !=
                         item.required_rights) begin
               rsp.status = ght_pkg::ST_RIGHTS;
            end else begin
               rsp.index      = {{(ght_pkg::INDEX_W-ght_pkg::IDX_W){1'b0}}, slot};
               rsp.generation = src_gen;
               rsp.object     = src_row.object;
               rsp.kind       = src_row.kind;
               rsp.rights     = src_row.rights;
               rsp.parent     = src_row.parent;
            end
         end
         ght_pkg::ACT_DERIVE: begin
            priority if (!handle_ok) begin
               rsp.status = ght_pkg::ST_STALE;
            end else if ((src_row.rights & derive_mask) != derive_mask) begin
               rsp.status = ght_pkg::ST_NO_DERIVE;
            end else if (full) begin
               rsp.status = ght_pkg::ST_FULL;
            end else begin
               upd.take       = 1'b1;
               new_row.kind   = src_row.kind;
               new_row.rights = src_row.rights & item.rights_value;
               new_row.object = src_row.object;
               new_row.parent = {1'b0, slot};
            end
         end
      endcase

      if (upd.take) begin
         // The new entry goes to the head of the free list. Its generation is
         // written back too, so a slot taken for the first time holds zero.
         upd.data_wr    = 1'b1;
         upd.data_row   = new_row;
         upd.gen_wr     = 1'b1;
         upd.rel_addr   = head[ght_pkg::IDX_W-1:0];
         upd.gen_val    = head_gen;
         upd.head_in    = head_link;
         upd.mark_in    = (head == mark) ? mark + 1'b1 : mark;
         upd.count_in   = count + 1'b1;
         rsp.index      = {{(ght_pkg::INDEX_W-ght_pkg::IDX_W){1'b0}},
                           head[ght_pkg::IDX_W-1:0]};
         rsp.generation = head_gen;
         rsp.object     = new_row.object;
         rsp.kind       = new_row.kind;
         rsp.rights     = new_row.rights;
         rsp.parent     = new_row.parent;
      end

      if (upd.drop) begin
         // The freed slot becomes the new head; object and parent are kept.
         upd.data_wr         = 1'b1;
         upd.data_addr       = slot;
         upd.data_row        = src_row;
         upd.data_row.kind   = '0;
         upd.data_row.rights = '0;
         upd.gen_wr          = 1'b1;
         upd.head_in         = {1'b0, slot};
         upd.count_in        = count - 1'b1;
         rsp.index           = {{(ght_pkg::INDEX_W-ght_pkg::IDX_W){1'b0}}, slot};
         rsp.generation      = upd.gen_val;
      end

      rsp.live_count = upd.count_in;
   end

endmodule

@@ design/generation_handle_table.sv @@
// Top level of the generation handle table: slot storage, free list and
// channel handshakes. Depends on ght_pkg, ght_ram and ght_exec.
//
// Usage: a request transaction on the req_ channel carries an action (insert,
// remove, lookup, derive) and the handle fields; each request yields exactly
// one response transaction on the rsp_ channel with a status, the handle and
// entry fields, and the number of live slots after the action.
// A transaction is taken on a rising clock edge with valid high and stall low.
// The request is registered at its accept edge, the entry memories are read
// at that same edge, and the response register loads when the decision stage
// advances. One transaction per cycle is sustained unless stalled; the rate
// is set by the single decision stage between the request register and the
// response register, with a one-entry bypass covering the write of the
// previous transaction. A stalled response holds, the decision stage then
// holds its transaction, and req_stall rises until the response is taken.
// Reset empties the table: the memories are not swept, a fill mark tells
// which slots have ever been taken, and untaken slots read as empty with
// generation zero; the derive right mask resets to one. The user must write
// it through csr_wr_en and csr_wr_data while the block is idle (not enforced).
module generation_handle_table (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ght_pkg::ACTION_W-1:0]        req_action,
   input  logic [ght_pkg::INDEX_W-1:0]         req_slot_index,
   input  logic [ght_pkg::GEN_W-1:0]           req_slot_generation,
   input  logic [ght_pkg::OBJ_W-1:0]           req_object_ref,
   input  logic [ght_pkg::KIND_W-1:0]          req_object_kind,
   input  logic [ght_pkg::RIGHTS_W-1:0]        req_rights_value,
   input  logic [ght_pkg::RIGHTS_W-1:0]        req_rights_bound,
   input  logic [ght_pkg::RIGHTS_W-1:0]        req_required_rights,
   input  logic                                req_kind_check,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ght_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ght_pkg::INDEX_W-1:0]         rsp_result_index,
   output logic [ght_pkg::GEN_W-1:0]           rsp_result_generation,
   output logic [ght_pkg::OBJ_W-1:0]           rsp_result_object,
   output logic [ght_pkg::KIND_W-1:0]          rsp_result_kind,
   output logic [ght_pkg::RIGHTS_W-1:0]        rsp_result_rights,
   output logic [ght_pkg::LINK_W-1:0]          rsp_result_parent,
   output logic [ght_pkg::LINK_W-1:0]          rsp_live_count,

   input  logic                                csr_wr_en,
   input  logic [ght_pkg::RIGHTS_W-1:0]        csr_wr_data
);

   // Handshake and control.
   logic accept;
   logic advance;

   logic [ght_pkg::RIGHTS_W-1:0] mask_ff;

   logic              s1_vld_ff;
   ght_pkg::item_type s1_item_ff;
   ght_pkg::item_type item_in;

   // Free list head, fill mark and live count.
   logic [ght_pkg::LINK_W-1:0] head_ff;
   logic [ght_pkg::LINK_W-1:0] head_in;
   logic [ght_pkg::LINK_W-1:0] mark_ff;
   logic [ght_pkg::LINK_W-1:0] mark_in;
   logic [ght_pkg::LINK_W-1:0] count_ff;
   logic [ght_pkg::LINK_W-1:0] count_in;

   // Last generation write (with the free link written by a remove) and last
   // row write.
   logic                       rm_vld_ff;
   logic [ght_pkg::IDX_W-1:0]  rm_addr_ff;
   logic [ght_pkg::GEN_W-1:0]  rm_gen_ff;
   logic [ght_pkg::LINK_W-1:0] rm_link_ff;
   logic                       dat_vld_ff;
   logic [ght_pkg::IDX_W-1:0]  dat_addr_ff;
   ght_pkg::row_type           dat_row_ff;

   logic                 rsp_vld_ff;
   ght_pkg::result_type  rsp_ff;

   // Memory read data.
   logic [ght_pkg::ROW_W-1:0]  data_rd;
   logic [ght_pkg::GEN_W-1:0]  gen_a_rd;
   logic [ght_pkg::GEN_W-1:0]  gen_b_rd;
   logic [ght_pkg::LINK_W-1:0] link_rd;

   // Views of the source entry and of the free head for the decision stage.
   logic [ght_pkg::IDX_W-1:0]  slot;
   logic [ght_pkg::IDX_W-1:0]  head_slot;
   logic                       slot_taken;
   logic                       head_fresh;
   logic                       rm_hit_src;
   logic                       rm_hit_head;
   ght_pkg::row_type           src_row;
   logic [ght_pkg::GEN_W-1:0]  src_gen;
   logic [ght_pkg::GEN_W-1:0]  head_gen;
   logic [ght_pkg::LINK_W-1:0] head_link;

   ght_pkg::result_type rsp_in;
   ght_pkg::update_type upd;

   logic data_we;
   logic rel_we;
   logic gen_we;

   // The decision stage moves on when the response register is free or is
   // being emptied in this cycle.
   assign advance   = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in.action          = req_action;
      item_in.slot_index      = req_slot_index;
      item_in.slot_generation = req_slot_generation;
      item_in.object_ref      = req_object_ref;
      item_in.object_kind     = req_object_kind;
      item_in.rights_value    = req_rights_value;
      item_in.rights_bound    = req_rights_bound;
      item_in.required_rights = req_required_rights;
      item_in.kind_check      = req_kind_check;
   end

   // Source entry: slots at or above the fill mark were never taken and read
   // as empty. A row or generation written at the edge that accepted this
   // transaction is not in the memory output yet, so the bypass registers
   // supply it; they always hold the newest write to their address.
   assign slot        = s1_item_ff.slot_index[ght_pkg::IDX_W-1:0];
   assign slot_taken  = {1'b0, slot} < mark_ff;
   assign rm_hit_src  = rm_vld_ff && (rm_addr_ff == slot);

   always_comb begin
      if (!slot_taken) begin
         src_row        = '0;
         src_row.parent = ght_pkg::LINK_NONE;
         src_gen        = '0;
      end else begin
         if (dat_vld_ff && (dat_addr_ff == slot)) begin
            src_row = dat_row_ff;
         end else begin
            src_row = ght_pkg::row_type'(data_rd);
         end
         src_gen = rm_hit_src ? rm_gen_ff : gen_a_rd;
      end
   end

   // Free head: the head memories are read at the head's next value every
   // cycle. A head equal to the fill mark is a slot never taken, whose link
   // is simply the following slot. A taken slot leaves the head at once, so
   // a bypass hit on the head always comes from a remove.
   assign head_slot   = head_ff[ght_pkg::IDX_W-1:0];
   assign head_fresh  = (head_ff == mark_ff);
   assign rm_hit_head = rm_vld_ff && (rm_addr_ff == head_slot);

   always_comb begin
      if (head_fresh) begin
         head_gen  = '0;
         head_link = head_ff + 1'b1;
      end else if (rm_hit_head) begin
         head_gen  = rm_gen_ff;
         head_link = rm_link_ff;
      end else begin
         head_gen  = gen_b_rd;
         head_link = link_rd;
      end
   end

   ght_exec u_exec (
      .item        (s1_item_ff),
      .src_row     (src_row),
      .src_gen     (src_gen),
      .head        (head_ff),
      .head_gen    (head_gen),
      .head_link   (head_link),
      .mark        (mark_ff),
      .count       (count_ff),
      .derive_mask (mask_ff),
      .rsp         (rsp_in),
      .upd         (upd)
   );

   assign head_in  = advance ? upd.head_in  : head_ff;
   assign mark_in  = advance ? upd.mark_in  : mark_ff;
   assign count_in = advance ? upd.count_in : count_ff;
   assign data_we  = advance && upd.data_wr;
   assign rel_we   = advance && upd.drop;
   assign gen_we   = advance && upd.gen_wr;

   // Entry rows, read at the requested slot when a transaction is accepted.
   ght_ram #(.WIDTH(ght_pkg::ROW_W), .DEPTH(ght_pkg::SLOTS)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (upd.data_addr),
      .wr_data (upd.data_row),
      .rd_en   (accept),
      .rd_addr (req_slot_index[ght_pkg::IDX_W-1:0]),
      .rd_data (data_rd)
   );

   // Two copies of the generations: one read at the requested slot, one at
   // the free head. Both are written on every take and every remove.
   ght_ram #(.WIDTH(ght_pkg::GEN_W), .DEPTH(ght_pkg::SLOTS)) u_gen_src_ram (
      .clock   (clock),
      .wr_en   (gen_we),
      .wr_addr (upd.rel_addr),
      .wr_data (upd.gen_val),
      .rd_en   (accept),
      .rd_addr (req_slot_index[ght_pkg::IDX_W-1:0]),
      .rd_data (gen_a_rd)
   );

   ght_ram #(.WIDTH(ght_pkg::GEN_W), .DEPTH(ght_pkg::SLOTS)) u_gen_head_ram (
      .clock   (clock),
      .wr_en   (gen_we),
      .wr_addr (upd.rel_addr),
      .wr_data (upd.gen_val),
      .rd_en   (1'b1),
      .rd_addr (head_in[ght_pkg::IDX_W-1:0]),
      .rd_data (gen_b_rd)
   );

   // Free list links, written when a slot is pushed back.
   ght_ram #(.WIDTH(ght_pkg::LINK_W), .DEPTH(ght_pkg::SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (rel_we),
      .wr_addr (upd.rel_addr),
      .wr_data (upd.link_val),
      .rd_en   (1'b1),
      .rd_addr (head_in[ght_pkg::IDX_W-1:0]),
      .rd_data (link_rd)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= ght_pkg::RIGHTS_W'(1);
         s1_vld_ff  <= 1'b0;
         head_ff    <= '0;
         mark_ff    <= '0;
         count_ff   <= '0;
         rm_vld_ff  <= 1'b0;
         dat_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
         if (accept) begin
            s1_vld_ff <= 1'b1;
         end else if (advance) begin
            s1_vld_ff <= 1'b0;
         end
         head_ff  <= head_in;
         mark_ff  <= mark_in;
         count_ff <= count_in;
         if (gen_we) begin
            rm_vld_ff <= 1'b1;
         end
         if (data_we) begin
            dat_vld_ff <= 1'b1;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= item_in;
      end
      if (gen_we) begin
         rm_addr_ff <= upd.rel_addr;
         rm_gen_ff  <= upd.gen_val;
         rm_link_ff <= upd.link_val;
      end
      if (data_we) begin
         dat_addr_ff <= upd.data_addr;
         dat_row_ff  <= upd.data_row;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid             = rsp_vld_ff;
   assign rsp_status            = rsp_ff.status;
   assign rsp_result_index      = rsp_ff.index;
   assign rsp_result_generation = rsp_ff.generation;
   assign rsp_result_object     = rsp_ff.object;
   assign rsp_result_kind       = rsp_ff.kind;
   assign rsp_result_rights     = rsp_ff.rights;
   assign rsp_result_parent     = rsp_ff.parent;
   assign rsp_live_count        = rsp_ff.live_count;

   // The free head is either a reused slot below the fill mark or the mark.
   a_head_below_mark: assert property (@(posedge clock) disable iff (reset)
      head_ff <= mark_ff)
      else $error("free head beyond fill mark");

   // Live slots were all taken at some point.
   a_count_below_mark: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mark_ff)
      else $error("live count beyond fill mark");

   // An empty free list means every slot is live.
   a_full_means_all_live: assert property (@(posedge clock) disable iff (reset)
      (head_ff == ght_pkg::LINK_NONE) |-> (count_ff == ght_pkg::LINK_NONE))
      else $error("free list empty while slots are free");

   // A successful insert or derive adds exactly one live slot.
   a_take_counts: assert property (@(posedge clock) disable iff (reset)
      (advance && upd.take) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("take did not bump the live count");

   // A completed remove puts the freed slot at the head of the free list.
   a_release_heads: assert property (@(posedge clock) disable iff (reset)
      (advance && upd.drop) |=> (head_ff == {1'b0, $past(upd.rel_addr)}))
      else $error("freed slot not at free head");

endmodule
